// ===== design/hrkd_pkg.sv =====
`default_nettype none

package hrkd_pkg;

  localparam int NUM_EV   = 13;
  localparam int Q_DEPTH  = 4;

  localparam logic [3:0] KEY_PLAY    = 4'd0;
  localparam logic [3:0] KEY_MUTE    = 4'd1;
  localparam logic [3:0] KEY_NEXT    = 4'd2;
  localparam logic [3:0] KEY_PREV    = 4'd3;
  localparam logic [3:0] KEY_VOLUP   = 4'd4;
  localparam logic [3:0] KEY_VOLDOWN = 4'd5;
  localparam logic [3:0] KEY_C       = 4'd6;
  localparam logic [3:0] KEY_V       = 4'd7;
  localparam logic [3:0] KEY_Y       = 4'd8;
  localparam logic [3:0] KEY_Z       = 4'd9;
  localparam logic [3:0] KEY_LCTRL   = 4'd10;
  localparam logic [3:0] KEY_RCTRL   = 4'd11;

  localparam logic [6:0] KBD_LEN   = 7'd8;
  localparam logic [6:0] MIN_LEN   = 7'd2;
  localparam logic [7:0] CTRL_MASK = 8'h11;

  // entry 0: ctrl, entries 1..6: presses, entries 7..12: releases
  localparam int EV_CTRL  = 0;
  localparam int EV_PRESS = 1;
  localparam int EV_REL   = 7;

  typedef struct packed {
    logic [NUM_EV-1:0]      vld;
    logic [NUM_EV-1:0][3:0] code;
    logic [NUM_EV-1:0]      press;
  } hrkd_job_t;

  // {hit, code}
  function automatic logic [4:0] kbd_map(input logic [7:0] k);
    logic [4:0] r;
    unique case (k)
      8'h06:   r = {1'b1, KEY_C};
      8'h19:   r = {1'b1, KEY_V};
      8'h1C:   r = {1'b1, KEY_Y};
      8'h1D:   r = {1'b1, KEY_Z};
      8'hE0:   r = {1'b1, KEY_LCTRL};
      8'hE4:   r = {1'b1, KEY_RCTRL};
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] consumer_map(input logic [15:0] u);
    logic [4:0] r;
    unique case (u)
      16'h00CD: r = {1'b1, KEY_PLAY};
      16'h00E2: r = {1'b1, KEY_MUTE};
      16'h00B5: r = {1'b1, KEY_NEXT};
      16'h00B6: r = {1'b1, KEY_PREV};
      16'h00E9: r = {1'b1, KEY_VOLUP};
      16'h00EA: r = {1'b1, KEY_VOLDOWN};
      default:  r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/hid_report_key_transition_diff.sv =====
// HID report key transition differ. Each request carries one HID input report
// (length and first eight bytes); eight-byte reports are diffed against the
// previous report as boot keyboard reports (ctrl, then presses in slot order,
// then releases), other lengths of two or more are decoded as consumer usages
// (press then release). Each report yields 0 to 13 transitions; out_last
// marks the final one. Reports that produce no transition emit nothing but
// still replace the stored report. A report is taken every cycle while the
// job queue (Q_DEPTH entries) has room; the output side emits one transition
// per cycle while out_ready does not stall it. A report reaches the output
// through the job queue, the back end's job register and the output register.
`default_nettype none

module hid_report_key_transition_diff #(
  parameter int Q_DEPTH = hrkd_pkg::Q_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [6:0] in_report_len,
  input  wire logic [7:0] in_byte0,
  input  wire logic [7:0] in_byte1,
  input  wire logic [7:0] in_byte2,
  input  wire logic [7:0] in_byte3,
  input  wire logic [7:0] in_byte4,
  input  wire logic [7:0] in_byte5,
  input  wire logic [7:0] in_byte6,
  input  wire logic [7:0] in_byte7,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [3:0]      out_key_code,
  output logic            out_pressed,
  output logic            out_last
);
  import hrkd_pkg::*;

  hrkd_job_t push_data, pop_data;
  logic      q_push, q_full, q_pop, q_valid;

  hrkd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_report_len (in_report_len),
    .in_byte0      (in_byte0),
    .in_byte1      (in_byte1),
    .in_byte2      (in_byte2),
    .in_byte3      (in_byte3),
    .in_byte4      (in_byte4),
    .in_byte5      (in_byte5),
    .in_byte6      (in_byte6),
    .in_byte7      (in_byte7),
    .q_push        (q_push),
    .q_full        (q_full),
    .q_data        (push_data)
  );

  hrkd_queue #(
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (push_data),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (pop_data)
  );

  hrkd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_data       (pop_data),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_key_code (out_key_code),
    .out_pressed  (out_pressed),
    .out_last     (out_last)
  );

endmodule

`default_nettype wire

// ===== design/hrkd_front.sv =====
`default_nettype none

module hrkd_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [6:0]        in_report_len,
  input  wire logic [7:0]        in_byte0,
  input  wire logic [7:0]        in_byte1,
  input  wire logic [7:0]        in_byte2,
  input  wire logic [7:0]        in_byte3,
  input  wire logic [7:0]        in_byte4,
  input  wire logic [7:0]        in_byte5,
  input  wire logic [7:0]        in_byte6,
  input  wire logic [7:0]        in_byte7,
  output logic                   q_push,
  input  wire logic              q_full,
  output hrkd_pkg::hrkd_job_t    q_data
);
  import hrkd_pkg::*;

  logic [3:0] prev_len_r, prev_len_nxt;
  logic [7:0] prev_mod_r;
  logic [7:0] prev_key_r [6];

  logic [7:0] cur_k [6];
  logic [5:0] old_on;
  logic       kbd, cons, acc;
  logic       now_c, prev_c;
  logic [4:0] cmap;
  logic [4:0] km;
  logic       hit;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign kbd      = (in_report_len == KBD_LEN);
  assign cons     = !kbd && (in_report_len >= MIN_LEN);
  assign cmap     = consumer_map({in_byte1, in_byte0});

  assign cur_k[0] = in_byte2;
  assign cur_k[1] = in_byte3;
  assign cur_k[2] = in_byte4;
  assign cur_k[3] = in_byte5;
  assign cur_k[4] = in_byte6;
  assign cur_k[5] = in_byte7;

  assign now_c  = (in_byte0 & CTRL_MASK) != 8'd0;
  assign prev_c = (prev_len_r == 4'(KBD_LEN)) && ((prev_mod_r & CTRL_MASK) != 8'd0);
  assign prev_len_nxt = (in_report_len > 7'd15) ? 4'd15 : in_report_len[3:0];

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      old_on[j] = prev_len_r > 4'(j + 2);
    end
  end

  always_comb begin
    q_data = '0;
    km     = '0;
    hit    = 1'b0;
    q_data.vld[EV_CTRL]   = kbd && (now_c != prev_c);
    q_data.code[EV_CTRL]  = KEY_LCTRL;
    q_data.press[EV_CTRL] = now_c;
    for (int i = 0; i < 6; i++) begin
      hit = 1'b0;
      for (int j = 0; j < 6; j++) begin
        hit = hit | (old_on[j] && (prev_key_r[j] == cur_k[i]));
      end
      km = kbd_map(cur_k[i]);
      q_data.vld[EV_PRESS+i]   = kbd && (cur_k[i] != 8'd0) && !hit && km[4];
      q_data.code[EV_PRESS+i]  = km[3:0];
      q_data.press[EV_PRESS+i] = 1'b1;
    end
    for (int j = 0; j < 6; j++) begin
      hit = 1'b0;
      for (int i = 0; i < 6; i++) begin
        hit = hit | (cur_k[i] == prev_key_r[j]);
      end
      km = kbd_map(prev_key_r[j]);
      q_data.vld[EV_REL+j]   = kbd && old_on[j] && (prev_key_r[j] != 8'd0) && !hit && km[4];
      q_data.code[EV_REL+j]  = km[3:0];
      q_data.press[EV_REL+j] = 1'b0;
    end
    if (cons) begin
      q_data.vld[EV_PRESS]   = cmap[4];
      q_data.code[EV_PRESS]  = cmap[3:0];
      q_data.vld[EV_REL]     = cmap[4];
      q_data.code[EV_REL]    = cmap[3:0];
    end
  end

  assign q_push = acc && (q_data.vld != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_len_r <= '0;
      prev_mod_r <= '0;
      for (int j = 0; j < 6; j++) begin
        prev_key_r[j] <= '0;
      end
    end else if (acc) begin
      prev_len_r <= prev_len_nxt;
      prev_mod_r <= in_byte0;
      for (int j = 0; j < 6; j++) begin
        prev_key_r[j] <= cur_k[j];
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/hrkd_queue.sv =====
`default_nettype none

module hrkd_queue #(
  parameter int DEPTH = hrkd_pkg::Q_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire hrkd_pkg::hrkd_job_t wdata,
  output logic                   full,
  input  wire logic              pop,
  output logic                   rvalid,
  output hrkd_pkg::hrkd_job_t    rdata
);
  import hrkd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  hrkd_job_t      mem_r [DEPTH];
  logic [PW-1:0]  wptr_r, rptr_r;
  logic [CW-1:0]  cnt_r;
  logic           do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign rvalid  = (cnt_r != '0);
  assign rdata   = mem_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && rvalid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/hrkd_back.sv =====
`default_nettype none

module hrkd_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire hrkd_pkg::hrkd_job_t q_data,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [3:0]             out_key_code,
  output logic                   out_pressed,
  output logic                   out_last
);
  import hrkd_pkg::*;

  logic                   job_vld_r;
  logic [NUM_EV-1:0]      mask_r, mask_nxt;
  logic [NUM_EV-1:0][3:0] code_r;
  logic [NUM_EV-1:0]      press_r;
  logic [NUM_EV-1:0]      pick;
  logic [3:0]             sel_code;
  logic                   sel_press;
  logic                   adv, rem_empty;

  logic       out_valid_r;
  logic [3:0] out_code_r;
  logic       out_press_r, out_last_r;

  always_comb begin
    pick      = '0;
    sel_code  = '0;
    sel_press = 1'b0;
    for (int i = NUM_EV - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        pick      = '0;
        pick[i]   = 1'b1;
        sel_code  = code_r[i];
        sel_press = press_r[i];
      end
    end
  end

  assign mask_nxt  = mask_r & ~pick;
  assign rem_empty = (mask_nxt == '0);
  assign adv       = job_vld_r && (!out_valid_r || out_ready);
  assign q_pop     = q_valid && (!job_vld_r || (adv && rem_empty));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_vld_r <= 1'b0;
      mask_r    <= '0;
    end else if (q_pop) begin
      job_vld_r <= 1'b1;
      mask_r    <= q_data.vld;
    end else if (adv) begin
      job_vld_r <= !rem_empty;
      mask_r    <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      code_r  <= q_data.code;
      press_r <= q_data.press;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_code_r  <= sel_code;
      out_press_r <= sel_press;
      out_last_r  <= rem_empty;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_key_code = out_code_r;
  assign out_pressed  = out_press_r;
  assign out_last     = out_last_r;

endmodule

`default_nettype wire

// ===== design/hrkd_checker.sv =====
`default_nettype none

module hrkd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [3:0] out_key_code,
  input wire logic       out_pressed,
  input wire logic       out_last
);
  import hrkd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_key_code)
      && $stable(out_pressed) && $stable(out_last))
    else $error("request dropped or changed while stalled");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_key_code <= KEY_RCTRL)
    else $error("key code out of range");

  a_cons_press: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_key_code <= KEY_VOLDOWN && out_pressed |-> !out_last)
    else $error("consumer press marked last");

  a_cons_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_key_code <= KEY_VOLDOWN && !out_pressed |-> out_last)
    else $error("consumer release not marked last");

endmodule

bind hid_report_key_transition_diff hrkd_checker u_hrkd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_key_code (out_key_code),
  .out_pressed  (out_pressed),
  .out_last     (out_last)
);

`default_nettype wire

// ===== dv/hid_report_key_transition_diff_tb.sv =====
module hid_report_key_transition_diff_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hrkd_pkg::*;

  localparam int RANDOM_REPORTS = 408;
  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int DRAIN_CYCLES   = 12;
  localparam int MAX_PRINTED    = 40;

  // keyboard scan codes
  localparam logic [7:0] SC_NONE  = 8'h00;
  localparam logic [7:0] SC_C     = 8'h06;
  localparam logic [7:0] SC_V     = 8'h19;
  localparam logic [7:0] SC_Y     = 8'h1C;
  localparam logic [7:0] SC_Z     = 8'h1D;
  localparam logic [7:0] SC_LCTRL = 8'hE0;
  localparam logic [7:0] SC_RCTRL = 8'hE4;
  localparam logic [7:0] SC_A     = 8'h04;

  // modifier bits
  localparam logic [7:0] MOD_NONE  = 8'h00;
  localparam logic [7:0] MOD_LCTRL = 8'h01;
  localparam logic [7:0] MOD_RCTRL = 8'h10;
  localparam logic [7:0] MOD_BOTH  = 8'h11;

  // consumer usages
  localparam logic [15:0] US_PLAY    = 16'h00CD;
  localparam logic [15:0] US_MUTE    = 16'h00E2;
  localparam logic [15:0] US_NEXT    = 16'h00B5;
  localparam logic [15:0] US_PREV    = 16'h00B6;
  localparam logic [15:0] US_VOLUP   = 16'h00E9;
  localparam logic [15:0] US_VOLDOWN = 16'h00EA;

  typedef logic [7:0][7:0] bytes_t;

  typedef struct {
    logic [6:0] len;
    bytes_t     b;
    bit         drain;
  } report_t;

  typedef struct {
    logic [3:0] code;
    logic       pressed;
    logic       last;
  } transition_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [6:0] in_report_len = '0;
  logic [7:0] in_byte0 = '0;
  logic [7:0] in_byte1 = '0;
  logic [7:0] in_byte2 = '0;
  logic [7:0] in_byte3 = '0;
  logic [7:0] in_byte4 = '0;
  logic [7:0] in_byte5 = '0;
  logic [7:0] in_byte6 = '0;
  logic [7:0] in_byte7 = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [3:0] out_key_code;
  logic       out_pressed;
  logic       out_last;

  report_t     report_backlog[$];
  transition_t pending_transitions[$];
  report_t     on_bus;

  logic [3:0] stored_len = '0;
  bytes_t     stored_bytes = '0;

  int  reports_queued = 0;
  int  reports_sent = 0;
  int  transitions_seen = 0;
  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  kbd_reports = 0;
  int  consumer_reports = 0;
  int  short_reports = 0;
  int  busiest_report = 0;
  int  send_gap = 0;
  int  sink_gap = 0;
  bit  in_calm = 1'b0;
  bit  out_calm = 1'b0;

  hid_report_key_transition_diff dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_report_len(in_report_len),
    .in_byte0     (in_byte0),
    .in_byte1     (in_byte1),
    .in_byte2     (in_byte2),
    .in_byte3     (in_byte3),
    .in_byte4     (in_byte4),
    .in_byte5     (in_byte5),
    .in_byte6     (in_byte6),
    .in_byte7     (in_byte7),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_key_code (out_key_code),
    .out_pressed  (out_pressed),
    .out_last     (out_last)
  );

  always #10 clk = ~clk;

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("[%0t] MISMATCH %s", $realtime, msg);
    end
  endtask

  function automatic void kbd_key_lookup(input logic [7:0] sc, output bit hit,
                                         output logic [3:0] code);
    hit = 1'b1;
    code = KEY_C;
    case (sc)
      SC_C:     code = KEY_C;
      SC_V:     code = KEY_V;
      SC_Y:     code = KEY_Y;
      SC_Z:     code = KEY_Z;
      SC_LCTRL: code = KEY_LCTRL;
      SC_RCTRL: code = KEY_RCTRL;
      default:  hit = 1'b0;
    endcase
  endfunction

  // nonzero and present in slots 2..min(n,8)-1
  function automatic bit key_in_slots(input bytes_t s, input int n, input logic [7:0] sc);
    int i;
    if (sc == SC_NONE) return 1'b0;
    for (i = 2; i < n && i < 8; i++) begin
      if (s[i] == sc) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void expect_key(input logic [3:0] code, input logic down);
    transition_t t;
    t.code = code;
    t.pressed = down;
    t.last = 1'b0;
    pending_transitions.push_back(t);
  endfunction

  function automatic void predict_transitions(input report_t r);
    bytes_t      old_b;
    int          old_len;
    int          first;
    int          i;
    bit          hit;
    bit          was_ctrl;
    bit          now_ctrl;
    logic [3:0]  code;
    logic [15:0] usage;
    first = pending_transitions.size();
    old_b = stored_bytes;
    old_len = stored_len;
    stored_bytes = r.b;
    stored_len = (r.len > 7'd15) ? 4'd15 : r.len[3:0];
    if (r.len == KBD_LEN) begin
      kbd_reports++;
      was_ctrl = (old_len == 8) && ((old_b[0] & CTRL_MASK) != 8'h00);
      now_ctrl = (r.b[0] & CTRL_MASK) != 8'h00;
      if (now_ctrl != was_ctrl) expect_key(KEY_LCTRL, now_ctrl);
      for (i = 2; i < 8; i++) begin
        if (r.b[i] != SC_NONE && !key_in_slots(old_b, old_len, r.b[i])) begin
          kbd_key_lookup(r.b[i], hit, code);
          if (hit) expect_key(code, 1'b1);
        end
      end
      for (i = 2; i < old_len && i < 8; i++) begin
        if (old_b[i] != SC_NONE && !key_in_slots(r.b, 8, old_b[i])) begin
          kbd_key_lookup(old_b[i], hit, code);
          if (hit) expect_key(code, 1'b0);
        end
      end
    end else if (r.len >= MIN_LEN) begin
      consumer_reports++;
      usage = {r.b[1], r.b[0]};
      hit = 1'b1;
      code = KEY_PLAY;
      case (usage)
        US_PLAY:    code = KEY_PLAY;
        US_MUTE:    code = KEY_MUTE;
        US_NEXT:    code = KEY_NEXT;
        US_PREV:    code = KEY_PREV;
        US_VOLUP:   code = KEY_VOLUP;
        US_VOLDOWN: code = KEY_VOLDOWN;
        default:    hit = 1'b0;
      endcase
      if (hit) begin
        expect_key(code, 1'b1);
        expect_key(code, 1'b0);
      end
    end else begin
      short_reports++;
    end
    if (pending_transitions.size() > first) begin
      pending_transitions[$].last = 1'b1;
    end
    if (pending_transitions.size() - first > busiest_report) begin
      busiest_report = pending_transitions.size() - first;
    end
  endfunction

  function automatic int idle_cycles(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(16, 40);
  endfunction

  function automatic logic [7:0] pick_scan_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return SC_NONE;
    if (r < 85) begin
      case ($urandom_range(0, 5))
        0: return SC_C;
        1: return SC_V;
        2: return SC_Y;
        3: return SC_Z;
        4: return SC_LCTRL;
        default: return SC_RCTRL;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_modifier();
    case ($urandom_range(0, 4))
      0: return MOD_NONE;
      1: return MOD_LCTRL;
      2: return MOD_RCTRL;
      3: return MOD_BOTH;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [15:0] pick_usage();
    case ($urandom_range(0, 7))
      0: return US_PLAY;
      1: return US_MUTE;
      2: return US_NEXT;
      3: return US_PREV;
      4: return US_VOLUP;
      5: return US_VOLDOWN;
      6: return 16'($urandom_range(0, 255));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [6:0] pick_consumer_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 7'($urandom_range(2, 7));
    if (r < 85) return 7'($urandom_range(9, 64));
    return 7'($urandom_range(65, 127));
  endfunction

  task automatic add_report(input logic [6:0] len, input logic [7:0] b0, input logic [7:0] b1,
                            input logic [7:0] k2, input logic [7:0] k3,
                            input logic [7:0] k4, input logic [7:0] k5,
                            input logic [7:0] k6, input logic [7:0] k7, input bit drain);
    report_t r;
    r.len = len;
    r.b = {k7, k6, k5, k4, k3, k2, b1, b0};
    r.drain = drain;
    report_backlog.push_back(r);
    reports_queued++;
  endtask

  always @(posedge clk) begin : driver
    bit free;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      free = !in_valid;
      if (in_valid && in_ready) begin
        predict_transitions(on_bus);
        reports_sent++;
        free = 1'b1;
      end
      if (free) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (report_backlog.size() > 0 &&
                     !(report_backlog[0].drain && pending_transitions.size() > 0)) begin
          on_bus = report_backlog.pop_front();
          in_report_len <= on_bus.len;
          in_byte0 <= on_bus.b[0];
          in_byte1 <= on_bus.b[1];
          in_byte2 <= on_bus.b[2];
          in_byte3 <= on_bus.b[3];
          in_byte4 <= on_bus.b[4];
          in_byte5 <= on_bus.b[5];
          in_byte6 <= on_bus.b[6];
          in_byte7 <= on_bus.b[7];
          in_valid <= 1'b1;
          if ($urandom_range(0, 47) == 0) in_calm = !in_calm;
          send_gap = idle_cycles(in_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    transition_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        transitions_seen++;
        if (pending_transitions.size() == 0) begin
          flag_mismatch($sformatf("unexpected transition key %0d pressed %0b last %0b",
                                  out_key_code, out_pressed, out_last));
        end else begin
          want = pending_transitions.pop_front();
          if (out_key_code !== want.code)
            flag_mismatch($sformatf("transition %0d key_code %0d, want %0d",
                                    transitions_seen, out_key_code, want.code));
          if (out_pressed !== want.pressed)
            flag_mismatch($sformatf("transition %0d pressed %0b, want %0b",
                                    transitions_seen, out_pressed, want.pressed));
          if (out_last !== want.last)
            flag_mismatch($sformatf("transition %0d last %0b, want %0b",
                                    transitions_seen, out_last, want.last));
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 47) == 0) out_calm = !out_calm;
        sink_gap = idle_cycles(out_calm);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d requests sent, %0d transitions pending",
               cycle_count, reports_sent, reports_queued, pending_transitions.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    bytes_t      kb;
    logic [15:0] usage;
    int          n;
    int          i;
    int          kind;
    bit          drain;

    // directed: keyboard diffs
    add_report(KBD_LEN, MOD_NONE, 8'h00, SC_NONE, SC_NONE, SC_NONE, SC_NONE, SC_NONE, SC_NONE, 0);
    add_report(KBD_LEN, MOD_LCTRL, 8'h00, SC_C, SC_V, SC_Y, SC_Z, SC_LCTRL, SC_RCTRL, 0);
    add_report(KBD_LEN, MOD_RCTRL, 8'hFF, SC_NONE, SC_NONE, SC_NONE, SC_NONE, SC_NONE,
               SC_NONE, 0);
    add_report(KBD_LEN, MOD_NONE, 8'h00, SC_C, SC_C, SC_V, SC_NONE, SC_A, SC_RCTRL, 0);
    add_report(KBD_LEN, MOD_BOTH, 8'h00, SC_C, SC_C, SC_C, SC_V, SC_V, SC_V, 1);
    // ctrl change plus six presses and six releases
    add_report(KBD_LEN, MOD_NONE, 8'h00, SC_Y, SC_Z, SC_LCTRL, SC_RCTRL, SC_Y, SC_Z, 0);
    // consumer usages over the length range
    add_report(7'd2, US_PLAY[7:0], US_PLAY[15:8], 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0);
    add_report(7'd3, US_MUTE[7:0], US_MUTE[15:8], SC_C, SC_V, 8'h00, 8'h00, 8'h00, 8'h00, 0);
    add_report(7'd7, US_NEXT[7:0], US_NEXT[15:8], 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0);
    add_report(7'd9, US_PREV[7:0], US_PREV[15:8], 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0);
    add_report(7'd64, US_VOLUP[7:0], US_VOLUP[15:8], 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55,
               8'hAA, 0);
    add_report(7'd127, US_VOLDOWN[7:0], US_VOLDOWN[15:8], 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
               8'h00, 0);
    add_report(7'd65, US_PLAY[7:0], 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0);
    add_report(7'd2, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0);
    // short reports
    add_report(7'd0, US_PLAY[7:0], 8'h00, SC_C, SC_V, SC_Y, SC_Z, SC_LCTRL, SC_RCTRL, 0);
    add_report(7'd1, US_PLAY[7:0], 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0);
    // previous report shorter than a keyboard report
    add_report(7'd5, MOD_BOTH, 8'h00, SC_C, SC_C, SC_V, SC_Z, SC_Y, SC_NONE, 0);
    add_report(KBD_LEN, MOD_BOTH, 8'h00, SC_Y, SC_C, SC_V, SC_NONE, SC_NONE, SC_NONE, 0);
    add_report(7'd3, MOD_NONE, 8'h00, SC_V, SC_Y, SC_Z, SC_NONE, SC_NONE, SC_NONE, 0);
    add_report(KBD_LEN, MOD_NONE, 8'h00, SC_NONE, SC_NONE, SC_NONE, SC_NONE, SC_NONE, SC_Y, 0);
    // saturated previous length
    add_report(7'd40, MOD_LCTRL, 8'h00, SC_C, SC_V, SC_Y, SC_Z, SC_LCTRL, SC_RCTRL, 0);
    add_report(KBD_LEN, MOD_NONE, 8'h00, SC_C, SC_NONE, SC_NONE, SC_NONE, SC_NONE, SC_NONE, 1);
    add_report(KBD_LEN, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0);
    add_report(KBD_LEN, 8'hEE, 8'h00, SC_NONE, SC_NONE, SC_NONE, SC_NONE, SC_NONE, SC_NONE, 0);

    kb = '0;
    for (n = 0; n < RANDOM_REPORTS; n++) begin
      kind = $urandom_range(0, 99);
      drain = ($urandom_range(0, 63) == 0);
      if (kind < 60) begin
        for (i = 2; i < 8; i++) begin
          if ($urandom_range(0, 1) == 0) kb[i] = pick_scan_code();
        end
        kb[0] = pick_modifier();
        kb[1] = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : 8'h00;
        add_report(KBD_LEN, kb[0], kb[1], kb[2], kb[3], kb[4], kb[5], kb[6], kb[7], drain);
      end else if (kind < 85) begin
        usage = pick_usage();
        add_report(pick_consumer_len(), usage[7:0], usage[15:8],
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), drain);
      end else begin
        add_report((kind < 95) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(0, 1)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   pick_scan_code(), pick_scan_code(), pick_scan_code(),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), drain);
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (reports_sent < reports_queued) @(posedge clk);
    while (pending_transitions.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests: %0d keyboard, %0d consumer, %0d short; %0d key transitions checked",
             reports_sent, kbd_reports, consumer_reports, short_reports, transitions_seen);
    $display("most transitions from one request: %0d, run took %0d cycles",
             busiest_report, cycle_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
